// File: rtl/assert_macros.svh
// Assertion helpers for the RTL, included by the two-hash Bloom filter unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define BFT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define BFT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    `BFT_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

// File: rtl/bft_pkg.sv
package bft_pkg;

    localparam int COUNT_W       = 24;
    localparam int SIZE_W        = 5;
    localparam int HASH_W        = 32;
    localparam int HI_SHIFT      = 16;
    localparam int MIN_SIZE_LOG2 = 3;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [SIZE_W-1:0]  SIZE_RESET = 5'd16;
    localparam logic [SIZE_W-1:0]  SIZE_MIN   = 5'(MIN_SIZE_LOG2);

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_SIZE_LOG2 = 1'b0;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_PROBE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SECOND,
        ST_EVAL,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic en;
        logic we;
    } ram_ctl_t;

endpackage

// File: rtl/bloom_filter_two_hash_unit.sv
// Bloom filter with two indices per hash over a single-port bit memory.
// Insert and probe each access the memory at the first index on transfer, then
// at the second in ST_SECOND; a probe's result is registered in ST_EVAL once the
// result channel is free. The memory port, one access per filter bit, takes no
// input in ST_SECOND. A clear item sweeps the whole memory, taking no input; reset
// (aresetn low, synchronous) zeroes the count, sets size_log2 to 16 and does the same.
`include "assert_macros.svh"

module bloom_filter_two_hash_unit #(
    parameter int MAX_SIZE_LOG2 = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bft_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bft_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bft_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    // Input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_mode,
    input  logic [bft_pkg::HASH_W-1:0]       s_hash,
    input  logic                             s_batch_end,
    // Result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_match,
    output logic [bft_pkg::COUNT_W-1:0]      m_match_count
);

    import bft_pkg::*;

    localparam int DEPTH = 2 ** MAX_SIZE_LOG2;
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SIZE_LOG2);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]        size_log2_reg;
    logic [1:0]               mode_reg;
    logic [MAX_SIZE_LOG2-1:0] idx2_reg;
    logic                     last_reg;
    logic                     bit1_reg;
    logic [MAX_SIZE_LOG2-1:0] clr_cnt_reg;
    logic [COUNT_W-1:0]       batch_reg;
    logic                     m_valid_reg;
    logic                     m_match_reg;
    logic [COUNT_W-1:0]       m_match_count_reg;

    logic [SIZE_W-1:0]        size_eff;
    logic [MAX_SIZE_LOG2-1:0] idx_mask;
    logic [MAX_SIZE_LOG2-1:0] idx1;
    logic [MAX_SIZE_LOG2-1:0] idx2;
    logic                     out_free;
    logic                     accept;
    logic                     eval_fire;
    logic                     hit;
    logic [COUNT_W-1:0]       count_new;

    ram_ctl_t                 ram_ctl;
    logic [MAX_SIZE_LOG2-1:0] ram_addr;
    logic                     ram_wdata;
    logic                     ram_rdata;

    // Configuration port
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SIZE_LOG2) begin
            prdata[SIZE_W-1:0] = size_log2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg <= SIZE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SIZE_LOG2) begin
            size_log2_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // Index generation; the size is clamped to the supported range.
    always_comb begin
        if (size_log2_reg < SIZE_MIN) begin
            size_eff = SIZE_MIN;
        end else if (size_log2_reg > SIZE_MAX) begin
            size_eff = SIZE_MAX;
        end else begin
            size_eff = size_log2_reg;
        end
    end

    assign idx_mask = ~({MAX_SIZE_LOG2{1'b1}} << size_eff);
    assign idx1     = s_hash[MAX_SIZE_LOG2-1:0] & idx_mask;
    assign idx2     = s_hash[HI_SHIFT+MAX_SIZE_LOG2-1:HI_SHIFT] & idx_mask;

    // Handshake
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) || (state_reg == ST_EVAL && out_free);
    assign accept    = s_valid && s_ready;
    assign eval_fire = (state_reg == ST_EVAL) && out_free;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE, ST_EVAL: begin
                if (state_reg == ST_EVAL && !out_free) begin
                    state_next = ST_EVAL;
                end else if (accept) begin
                    case (s_mode)
                        MODE_CLEAR:  state_next = ST_CLEAR;
                        MODE_INSERT: state_next = ST_SECOND;
                        MODE_PROBE:  state_next = ST_SECOND;
                        default:     state_next = ST_IDLE;
                    endcase
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SECOND: begin
                state_next = (mode_reg == MODE_PROBE) ? ST_EVAL : ST_IDLE;
            end
            ST_CLEAR: begin
                state_next = (&clr_cnt_reg) ? ST_IDLE : ST_CLEAR;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory port control
    always_comb begin
        ram_ctl   = '0;
        ram_addr  = idx1;
        ram_wdata = 1'b1;
        case (state_reg)
            ST_IDLE, ST_EVAL: begin
                if (accept) begin
                    case (s_mode)
                        MODE_INSERT: begin
                            ram_ctl.en = 1'b1;
                            ram_ctl.we = 1'b1;
                        end
                        MODE_PROBE: begin
                            ram_ctl.en = 1'b1;
                        end
                        default: ram_ctl = '0;
                    endcase
                end
            end
            ST_SECOND: begin
                ram_ctl.en = 1'b1;
                ram_ctl.we = (mode_reg == MODE_INSERT);
                ram_addr   = idx2_reg;
            end
            ST_CLEAR: begin
                ram_ctl.en = 1'b1;
                ram_ctl.we = 1'b1;
                ram_addr   = clr_cnt_reg;
                ram_wdata  = 1'b0;
            end
            default: ram_ctl = '0;
        endcase
    end

    bft_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_bits (
        .aclk  (aclk),
        .en    (ram_ctl.en),
        .we    (ram_ctl.we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // In the evaluation cycle the read data holds the second filter bit.
    assign hit       = bit1_reg && ram_rdata;
    assign count_new = (hit && batch_reg != COUNT_MAX) ? batch_reg + 1'b1 : batch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            batch_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (eval_fire) begin
                batch_reg   <= last_reg ? '0 : count_new;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= s_mode;
            idx2_reg <= idx2;
            last_reg <= s_batch_end;
        end
        if (state_reg == ST_SECOND) begin
            bit1_reg <= ram_rdata;
        end
        if (eval_fire) begin
            m_match_reg       <= hit;
            m_match_count_reg <= count_new;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match       = m_match_reg;
    assign m_match_count = m_match_count_reg;

    `BFT_ASSERT_IMPL(a_no_accept_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_ready, "input accepted during clear sweep")
    `BFT_ASSERT_IMPL(a_probe_no_write, aclk, aresetn, state_reg == ST_SECOND && mode_reg == MODE_PROBE, !ram_ctl.we, "filter memory written during a probe")
    `BFT_ASSERT(a_result_from_eval, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg) == ST_EVAL, "result raised outside evaluation")
    `BFT_ASSERT_IMPL(a_match_counted, aclk, aresetn, m_valid_reg && m_match_reg, m_match_count_reg != '0, "match reported with zero count")

endmodule

// File: rtl/bft_ram.sv
module bft_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
